@@ design/range_set_tracker_unit_defines.svh @@
// Assertion macros for the range set tracker.
// Included by the top level; no other dependencies.
`ifndef RANGE_SET_TRACKER_UNIT_DEFINES_SVH
`define RANGE_SET_TRACKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("range_set_tracker: check failed");
`define RST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("range_set_tracker: check failed");
`else
`define RST_ASSERT(lbl, prop)
`define RST_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ design/rst_pkg.sv @@
// Shared constants and types for the range set tracker.
// No dependencies.
package rst_pkg;
  localparam int unsigned MaxRangesDef = 16;
  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned OpW          = 2;
  localparam int unsigned FieldW       = 32;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountOutW    = 5;

  localparam logic [OpW-1:0] OP_ADD    = 2'd0;
  localparam logic [OpW-1:0] OP_QUERY  = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;
  localparam logic [OpW-1:0] OP_RSVD   = 2'd3;  // unused code, always refused

  localparam logic [StatusW-1:0] ST_DONE    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL    = 2'd1;
  localparam logic [StatusW-1:0] ST_INVALID = 2'd2;

  typedef struct packed {
    logic shift;     // rotate the stored row by one cell
    logic commit;    // load the scratch row into the stored row
    logic push_one;  // write word A at the pointer
    logic push_two;  // write word A and word B after it
  } cell_ctl_t;
endpackage

@@ design/rst_cell.sv @@
// One cell of the range row: a stored entry and a scratch entry.
// Depends on rst_pkg.
module rst_cell #(
  parameter int unsigned COORD_BITS = rst_pkg::CoordBitsDef,
  parameter int unsigned PTR_W      = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  rst_pkg::cell_ctl_t    ctl_i,
  input  logic [PTR_W-1:0]      ptr_i,
  input  logic [COORD_BITS-1:0] nbr_start_i,
  input  logic [COORD_BITS-1:0] nbr_end_i,
  input  logic [COORD_BITS-1:0] a_start_i,
  input  logic [COORD_BITS-1:0] a_end_i,
  input  logic [COORD_BITS-1:0] b_start_i,
  input  logic [COORD_BITS-1:0] b_end_i,
  output logic [COORD_BITS-1:0] start_o,
  output logic [COORD_BITS-1:0] end_o
);
  logic [COORD_BITS-1:0] main_s_q, main_e_q, scr_s_q, scr_e_q;
  logic [COORD_BITS-1:0] scr_s_d, scr_e_d;
  logic                  wr_a, wr_b;

  assign wr_a = (ctl_i.push_one | ctl_i.push_two) && ({1'b0, ptr_i} == (PTR_W+1)'(IDX));
  assign wr_b = ctl_i.push_two && (({1'b0, ptr_i} + 1'b1) == (PTR_W+1)'(IDX));

  always_comb begin
    scr_s_d = scr_s_q;
    scr_e_d = scr_e_q;
    if (wr_a) begin
      scr_s_d = a_start_i;
      scr_e_d = a_end_i;
    end else if (wr_b) begin
      scr_s_d = b_start_i;
      scr_e_d = b_end_i;
    end
  end

  always_ff @(posedge clk_i) begin
    scr_s_q <= scr_s_d;
    scr_e_q <= scr_e_d;
    if (ctl_i.commit) begin
      main_s_q <= scr_s_d;
      main_e_q <= scr_e_d;
    end else if (ctl_i.shift) begin
      main_s_q <= nbr_start_i;
      main_e_q <= nbr_end_i;
    end
  end

  assign start_o = main_s_q;
  assign end_o   = main_e_q;
endmodule

@@ design/range_set_tracker_unit.sv @@
// Range set tracker: a sorted table of up to MAX_RANGES disjoint half-open ranges held in a
// row of cells. Each word (add, query, remove) rotates the whole row once past the head
// cell, one entry per cycle, while the head logic merges, cuts or tests the entry and writes
// results into the scratch row; a final state commits the scratch row of an add or remove if it
// fits. Refused words (empty or reversed ranges, or the reserved operation) skip the sweep. One
// word is in work at a time; the result sits in an output register. Depends on rst_pkg and
// range_set_tracker_unit_defines.svh.
`include "range_set_tracker_unit_defines.svh"
module range_set_tracker_unit #(
  parameter int unsigned MAX_RANGES = rst_pkg::MaxRangesDef,
  parameter int unsigned COORD_BITS = rst_pkg::CoordBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rst_pkg::OpW-1:0]       operation_i,
  input  logic [rst_pkg::FieldW-1:0]    range_left_i,
  input  logic [rst_pkg::FieldW-1:0]    range_right_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          covered_o,
  output logic [rst_pkg::StatusW-1:0]   status_o,
  output logic [rst_pkg::CountOutW-1:0] range_count_o
);
  localparam int unsigned KW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
  localparam int unsigned PTR_W = $clog2(MAX_RANGES + 3);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_FINAL} state_e;

  state_e                  state_q;
  logic [rst_pkg::OpW-1:0] op_q;
  logic [COORD_BITS-1:0]   l_q, r_q, l_d, r_d, l_in, r_in;
  logic                    placed_q, placed_d, hit_q, hit_d, bad_q;
  logic [PTR_W-1:0]        ptr_q, n_final;
  logic [KW-1:0]           k_q;
  logic [CW-1:0]           count_q;
  logic                    out_valid_q, covered_q;
  logic [rst_pkg::StatusW-1:0]   status_q;
  logic [rst_pkg::CountOutW-1:0] rcount_q;

  logic [COORD_BITS-1:0] cs [MAX_RANGES];
  logic [COORD_BITS-1:0] ce [MAX_RANGES];
  logic [COORD_BITS-1:0] hs, he, as_w, ae_w, bs_w, be_w;
  rst_pkg::cell_ctl_t    ctl;
  logic                  in_acc, leave, active, full, fin_push, in_bad;

  assign l_in   = COORD_BITS'(range_left_i);
  assign r_in   = COORD_BITS'(range_right_i);
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_bad = (l_in >= r_in) || (operation_i == rst_pkg::OP_RSVD);
  assign in_stall_o = (state_q != S_IDLE);
  assign leave  = (state_q == S_FINAL) && (!out_valid_q || !out_stall_i);
  assign active = (state_q == S_SWEEP) && (CW'(k_q) < count_q);
  assign hs     = cs[0];
  assign he     = ce[0];

  assign fin_push = leave && !bad_q && (op_q == rst_pkg::OP_ADD) && !placed_q;
  assign n_final  = ptr_q + PTR_W'(fin_push);
  assign full     = n_final > PTR_W'(MAX_RANGES);

  // head cell logic: one stored entry per cycle
  always_comb begin
    l_d      = l_q;
    r_d      = r_q;
    placed_d = placed_q;
    hit_d    = hit_q;
    as_w     = hs;
    ae_w     = he;
    bs_w     = hs;
    be_w     = he;
    ctl      = '0;
    ctl.shift  = (state_q == S_SWEEP);
    if (active) begin
      unique case (op_q)
        rst_pkg::OP_ADD: begin
          if (he < l_q) begin
            ctl.push_one = 1'b1;
          end else if (hs > r_q) begin
            if (!placed_q) begin
              as_w = l_q;
              ae_w = r_q;
              ctl.push_two = 1'b1;
              placed_d = 1'b1;
            end else begin
              ctl.push_one = 1'b1;
            end
          end else begin
            if (hs < l_q) l_d = hs;
            if (he > r_q) r_d = he;
          end
        end
        rst_pkg::OP_REMOVE: begin
          if (he <= l_q || hs >= r_q) begin
            ctl.push_one = 1'b1;
          end else if (hs < l_q && he > r_q) begin
            ae_w = l_q;
            bs_w = r_q;
            ctl.push_two = 1'b1;
          end else if (hs < l_q) begin
            ae_w = l_q;
            ctl.push_one = 1'b1;
          end else if (he > r_q) begin
            as_w = r_q;
            ctl.push_one = 1'b1;
          end
        end
        rst_pkg::OP_QUERY: begin
          if (hs <= l_q && he >= r_q) hit_d = 1'b1;
        end
        default: ;
      endcase
    end
    if (fin_push) begin
      as_w = l_q;
      ae_w = r_q;
      ctl.push_one = 1'b1;
    end
    ctl.commit = leave && !bad_q && !full &&
                 (op_q == rst_pkg::OP_ADD || op_q == rst_pkg::OP_REMOVE);
  end

  for (genvar i = 0; i < MAX_RANGES; i++) begin : g_cell
    localparam int unsigned Nbr = (i + 1) % MAX_RANGES;
    rst_cell #(.COORD_BITS(COORD_BITS), .PTR_W(PTR_W), .IDX(i)) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .ptr_i      (ptr_q),
      .nbr_start_i(cs[Nbr]),
      .nbr_end_i  (ce[Nbr]),
      .a_start_i  (as_w),
      .a_end_i    (ae_w),
      .b_start_i  (bs_w),
      .b_end_i    (be_w),
      .start_o    (cs[i]),
      .end_o      (ce[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      ptr_q       <= '0;
      k_q         <= '0;
      placed_q    <= 1'b0;
      hit_q       <= 1'b0;
      bad_q       <= 1'b0;
      op_q        <= rst_pkg::OP_ADD;
      l_q         <= '0;
      r_q         <= '0;
      covered_q   <= 1'b0;
      status_q    <= rst_pkg::ST_DONE;
      rcount_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !leave) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q     <= operation_i;
            l_q      <= l_in;
            r_q      <= r_in;
            bad_q    <= in_bad;
            ptr_q    <= '0;
            k_q      <= '0;
            placed_q <= 1'b0;
            hit_q    <= 1'b0;
            state_q  <= in_bad ? S_FINAL : S_SWEEP;
          end
        end
        S_SWEEP: begin
          l_q      <= l_d;
          r_q      <= r_d;
          placed_q <= placed_d;
          hit_q    <= hit_d;
          ptr_q    <= ptr_q + PTR_W'(ctl.push_one) + PTR_W'({ctl.push_two, 1'b0});
          k_q      <= k_q + 1'b1;
          if (k_q == KW'(MAX_RANGES - 1)) state_q <= S_FINAL;
        end
        S_FINAL: begin
          if (leave) begin
            out_valid_q <= 1'b1;
            covered_q   <= !bad_q && (op_q == rst_pkg::OP_QUERY) && hit_q;
            if (bad_q) begin
              status_q <= rst_pkg::ST_INVALID;
              rcount_q <= rst_pkg::CountOutW'(count_q);
            end else if (ctl.commit) begin
              status_q <= rst_pkg::ST_DONE;
              count_q  <= CW'(n_final);
              rcount_q <= rst_pkg::CountOutW'(n_final);
            end else begin
              status_q <= (op_q == rst_pkg::OP_QUERY) ? rst_pkg::ST_DONE : rst_pkg::ST_FULL;
              rcount_q <= rst_pkg::CountOutW'(count_q);
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign covered_o     = covered_q;
  assign status_o      = status_q;
  assign range_count_o = rcount_q;

  `RST_ASSERT(a_count_bound, count_q <= CW'(MAX_RANGES))
  `RST_ASSERT(a_accept_starts, in_acc |=> state_q != S_IDLE)
  `RST_ASSERT(a_result_from_final, $rose(out_valid_q) |-> $past(state_q == S_FINAL))
  `RST_ASSERT_ALWAYS(a_full_keeps, (leave && !bad_q && full) |=> $stable(count_q))
endmodule
